>>> hw/rtl/mini_risc_single_step_core_unit_defines.svh
// ----------------------------------------------------------------------------
// mini_risc_single_step_core_unit_defines.svh
// Assertion macros shared by the core's checker.
// ----------------------------------------------------------------------------
`ifndef MINI_RISC_SINGLE_STEP_CORE_UNIT_DEFINES_SVH
`define MINI_RISC_SINGLE_STEP_CORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MRSC_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MRSC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/mrsc_pkg.sv
// ----------------------------------------------------------------------------
// mrsc_pkg
// Shared constants, codes and types of the mini RISC single-step core.
// ----------------------------------------------------------------------------
package mrsc_pkg;

  localparam int PC_W           = 9;
  localparam int REG_COUNT      = 8;
  localparam int REG_AW         = $clog2(REG_COUNT);
  localparam int DATA_WORDS_DEF = 256;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int IO_W           = 16;
  localparam int MADDR_W        = 8;
  localparam int IMM_W          = 6;
  localparam int TGT_W          = 7;
  localparam int QUEUE_DEPTH    = 2;
  localparam int ARITH_LO       = -128;
  localparam int ARITH_HI       = 127;

  // Instruction field positions
  localparam int OPC_LSB = 12;
  localparam int RS_LSB  = 9;
  localparam int RT_LSB  = 6;
  localparam int RD_LSB  = 3;

  // Configuration port
  localparam int   CFG_AW                 = 3;
  localparam int   APB_DW                 = 32;
  localparam logic CFG_IDX_PROGRAM_LENGTH = 1'b0;

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [3:0] OPC_RTYPE = 4'd0;
  localparam logic [3:0] OPC_J     = 4'd2;
  localparam logic [3:0] OPC_ADDI  = 4'd4;
  localparam logic [3:0] OPC_BEQ   = 4'd8;
  localparam logic [3:0] OPC_LW    = 4'd11;
  localparam logic [3:0] OPC_SW    = 4'd15;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  // Request class as seen by the execute side
  typedef enum logic [3:0] {
    K_NONE,
    K_ADD,
    K_SUB,
    K_AND,
    K_OR,
    K_ADDI,
    K_LW,
    K_SW,
    K_BEQ,
    K_J,
    K_STEP,
    K_MWRITE,
    K_MREAD
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [REG_AW-1:0]        rs;
    logic [REG_AW-1:0]        rt;
    logic [REG_AW-1:0]        dst;
    logic signed [IMM_W-1:0]  imm;
    logic signed [TGT_W-1:0]  tgt;
    logic [MADDR_W-1:0]       addr;
    logic signed [IO_W-1:0]   value;
  } item_t;

  typedef struct packed {
    logic [PC_W-1:0]        next_pc;
    logic                   overflow_flag;
    logic signed [IO_W-1:0] read_value;
    logic                   done_res;
  } res_t;

endpackage

>>> hw/rtl/mrsc_fifo.sv
// ----------------------------------------------------------------------------
// mrsc_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module mrsc_fifo
  import mrsc_pkg::*;
#(
  parameter int WIDTH = IO_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

>>> hw/rtl/mrsc_front.sv
// ----------------------------------------------------------------------------
// mrsc_front
// Accepts requests, classifies them and queues them for the execute side.
// ----------------------------------------------------------------------------
module mrsc_front
  import mrsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             cmd,
  input  logic [IO_W-1:0]        instruction_word,
  input  logic [MADDR_W-1:0]     mem_addr,
  input  logic signed [IO_W-1:0] mem_value,
  input  logic                   hold,
  output logic                   item_valid,
  output item_t                  item,
  input  logic                   item_pop
);

  localparam int IW = $bits(item_t);

  item_t          dec;
  logic [3:0]     opcode;
  logic [2:0]     funct;
  logic [IW-1:0]  q_rdata;
  logic           q_full;
  logic           q_empty;

  assign opcode = instruction_word[OPC_LSB +: 4];
  assign funct  = instruction_word[2:0];

  // Classify the request; register slots come straight from the word.
  always_comb begin
    dec.kind  = K_NONE;
    dec.rs    = instruction_word[RS_LSB +: REG_AW];
    dec.rt    = instruction_word[RT_LSB +: REG_AW];
    dec.dst   = instruction_word[RT_LSB +: REG_AW];
    dec.imm   = signed'(instruction_word[IMM_W-1:0]);
    dec.tgt   = signed'(instruction_word[TGT_W-1:0]);
    dec.addr  = mem_addr;
    dec.value = mem_value;
    case (cmd)
      CMD_EXEC: begin
        dec.kind = K_STEP;
        dec.addr = MADDR_W'(dec.imm);
        case (opcode)
          OPC_RTYPE: begin
            dec.dst = instruction_word[RD_LSB +: REG_AW];
            case (funct)
              FN_ADD:  dec.kind = K_ADD;
              FN_SUB:  dec.kind = K_SUB;
              FN_AND:  dec.kind = K_AND;
              FN_OR:   dec.kind = K_OR;
              default: dec.kind = K_STEP;
            endcase
          end
          OPC_ADDI: dec.kind = K_ADDI;
          OPC_LW:   dec.kind = K_LW;
          OPC_SW:   dec.kind = K_SW;
          OPC_BEQ:  dec.kind = K_BEQ;
          OPC_J:    dec.kind = K_J;
          default:  dec.kind = K_STEP;
        endcase
      end
      CMD_WRITE: dec.kind = K_MWRITE;
      CMD_READ:  dec.kind = K_MREAD;
      default:   dec.kind = K_NONE;
    endcase
  end

  assign full       = q_full || hold;
  assign item_valid = !q_empty;
  assign item       = item_t'(q_rdata);

  mrsc_fifo #(
    .WIDTH (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !hold),
    .wdata (dec),
    .full  (q_full),
    .pop   (item_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

endmodule

>>> hw/rtl/mrsc_back.sv
// ----------------------------------------------------------------------------
// mrsc_back
// Execute side: register file, data memory, program counter and result queue.
// ----------------------------------------------------------------------------
module mrsc_back
  import mrsc_pkg::*;
#(
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  item_t           in_item,
  output logic            in_pop,
  input  logic [PC_W-1:0] program_length,
  output logic            clearing,
  input  logic            pop,
  output logic            empty,
  output res_t            res
);

  localparam int AW   = $clog2(DATA_WORDS);
  localparam int XW   = (AW + 1 > MADDR_W) ? AW + 1 : MADDR_W;
  localparam int NSUB = ((1 << MADDR_W) - 1) / DATA_WORDS;
  localparam int SW   = DATA_WIDTH + 1;
  localparam int TW   = PC_W + 1;
  localparam int RW   = $bits(res_t);
  localparam logic [AW-1:0] LAST_WORD = AW'(DATA_WORDS - 1);

  // Reduce an 8-bit address modulo the memory depth by compare and subtract.
  function automatic logic [AW-1:0] word_index(input logic [MADDR_W-1:0] a);
    logic [XW-1:0] x;
    x = XW'(a);
    for (int i = 0; i < NSUB; i++) begin
      if (x >= XW'(DATA_WORDS)) begin
        x = x - XW'(DATA_WORDS);
      end
    end
    return AW'(x);
  endfunction

  logic [DATA_WIDTH-1:0] rf [REG_COUNT];
  logic [REG_COUNT-1:0]  rf_ok;
  logic [DATA_WIDTH-1:0] mem [DATA_WORDS];

  logic                  clr_busy;
  logic [AW-1:0]         clr_addr;

  logic                  x_valid;
  item_t                 x_item;
  logic [AW-1:0]         x_addr;
  logic [DATA_WIDTH-1:0] x_rs_raw;
  logic [DATA_WIDTH-1:0] x_rt_raw;
  logic                  x_rs_ok;
  logic                  x_rt_ok;
  logic [DATA_WIDTH-1:0] x_mem_raw;

  logic                  frf_valid;
  logic [REG_AW-1:0]     frf_addr;
  logic [DATA_WIDTH-1:0] frf_data;
  logic                  fm_valid;
  logic [AW-1:0]         fm_addr;
  logic [DATA_WIDTH-1:0] fm_data;

  logic [PC_W-1:0]       pc;
  logic [PC_W-1:0]       pc_next;
  logic                  ovf;
  logic                  ovf_next;

  logic                  issue;
  logic                  x_go;
  logic                  out_full;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rs_v;
  logic [DATA_WIDTH-1:0] rt_v;
  logic [DATA_WIDTH-1:0] m_v;
  logic signed [SW-1:0]  a_s;
  logic signed [SW-1:0]  b_s;
  logic signed [SW-1:0]  arith;
  logic                  arith_ok;
  logic                  x_exec;
  logic                  x_done;
  logic signed [TW-1:0]  t1;
  logic                  jmp_take;
  logic signed [31:0]    val32;
  logic [31:0]           rd32;
  logic                  reg_wr;
  logic                  mem_wr;
  logic                  rf_we;
  logic [DATA_WIDTH-1:0] rf_wd;
  logic                  m_we;
  logic [AW-1:0]         m_wa;
  logic [DATA_WIDTH-1:0] m_wd;
  res_t                  x_res;
  logic [RW-1:0]         res_bits;

  assign clearing = clr_busy;
  assign x_go     = x_valid && !out_full;
  assign issue    = in_valid && !clr_busy && (!x_valid || x_go);
  assign in_pop   = issue;
  assign rd_addr  = word_index(in_item.addr);

  // Execute stage
  always_comb begin
    rs_v = (frf_valid && frf_addr == x_item.rs) ? frf_data :
           (x_rs_ok ? x_rs_raw : '0);
    rt_v = (frf_valid && frf_addr == x_item.rt) ? frf_data :
           (x_rt_ok ? x_rt_raw : '0);
    m_v  = (fm_valid && fm_addr == x_addr) ? fm_data : x_mem_raw;

    a_s = {rs_v[DATA_WIDTH-1], rs_v};
    if (x_item.kind == K_ADDI) begin
      b_s = SW'(x_item.imm);
    end else begin
      b_s = {rt_v[DATA_WIDTH-1], rt_v};
    end
    if (x_item.kind == K_SUB) begin
      arith = a_s - b_s;
    end else begin
      arith = a_s + b_s;
    end
    arith_ok = (arith >= SW'(ARITH_LO)) && (arith <= SW'(ARITH_HI));

    t1       = TW'(x_item.tgt) - TW'(1);
    jmp_take = t1[TW-1] || (t1[PC_W-1:0] < program_length);

    val32 = 32'(x_item.value);
    rd32  = 32'(m_v);

    x_exec = x_item.kind inside {K_ADD, K_SUB, K_AND, K_OR, K_ADDI, K_LW, K_SW,
                                 K_BEQ, K_J, K_STEP};
    x_done = x_exec && (pc >= program_length);

    pc_next  = pc;
    ovf_next = ovf;
    reg_wr   = 1'b0;
    mem_wr   = 1'b0;
    rf_wd    = '0;
    if (x_exec && !x_done) begin
      pc_next = pc + 1'b1;
      case (x_item.kind)
        K_ADD, K_SUB, K_ADDI: begin
          reg_wr = 1'b1;
          rf_wd  = arith_ok ? DATA_WIDTH'(arith) : '0;
          if (!arith_ok) begin
            ovf_next = 1'b1;
          end
        end
        K_AND: begin
          reg_wr = 1'b1;
          rf_wd  = rs_v & rt_v;
        end
        K_OR: begin
          reg_wr = 1'b1;
          rf_wd  = rs_v | rt_v;
        end
        K_LW: begin
          reg_wr = 1'b1;
          rf_wd  = m_v;
        end
        K_SW:    mem_wr = 1'b1;
        K_BEQ: begin
          if (rs_v == rt_v) begin
            pc_next = pc + PC_W'(x_item.imm) + 1'b1;
          end
        end
        K_J:     pc_next = jmp_take ? PC_W'(x_item.tgt) : t1[PC_W-1:0];
        default: pc_next = pc + 1'b1;
      endcase
    end
    if (x_item.kind == K_MWRITE) begin
      mem_wr = 1'b1;
    end

    rf_we = x_go && reg_wr;
    m_we  = clr_busy || (x_go && mem_wr);
    m_wa  = clr_busy ? clr_addr : x_addr;
    if (clr_busy) begin
      m_wd = '0;
    end else if (x_item.kind == K_SW) begin
      m_wd = rt_v;
    end else begin
      m_wd = DATA_WIDTH'(val32);
    end

    x_res.next_pc       = pc_next;
    x_res.overflow_flag = ovf_next;
    x_res.read_value    = (x_item.kind == K_MREAD) ? signed'(rd32[IO_W-1:0]) : '0;
    x_res.done_res      = x_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy  <= 1'b1;
      clr_addr  <= '0;
      x_valid   <= 1'b0;
      rf_ok     <= '0;
      frf_valid <= 1'b0;
      fm_valid  <= 1'b0;
      pc        <= '0;
      ovf       <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST_WORD) begin
          clr_busy <= 1'b0;
        end
      end
      if (issue) begin
        x_valid <= 1'b1;
      end else if (x_go) begin
        x_valid <= 1'b0;
      end
      if (rf_we) begin
        rf_ok[x_item.dst] <= 1'b1;
        frf_valid         <= 1'b1;
        frf_addr          <= x_item.dst;
        frf_data          <= rf_wd;
      end
      if (m_we) begin
        fm_valid <= 1'b1;
        fm_addr  <= m_wa;
        fm_data  <= m_wd;
      end
      if (x_go) begin
        pc  <= pc_next;
        ovf <= ovf_next;
      end
    end
  end

  // Register file: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[x_item.dst] <= rf_wd;
    end
    if (issue) begin
      x_item   <= in_item;
      x_addr   <= rd_addr;
      x_rs_raw <= rf[in_item.rs];
      x_rt_raw <= rf[in_item.rt];
      x_rs_ok  <= rf_ok[in_item.rs];
      x_rt_ok  <= rf_ok[in_item.rt];
    end
  end

  // Data memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (m_we) begin
      mem[m_wa] <= m_wd;
    end
    if (issue) begin
      x_mem_raw <= mem[rd_addr];
    end
  end

  assign res = res_t'(res_bits);

  mrsc_fifo #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (x_go),
    .wdata (x_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

endmodule

>>> hw/rtl/mini_risc_single_step_core_unit.sv
// ----------------------------------------------------------------------------
// mini_risc_single_step_core_unit
// 16-bit MIPS-like core that executes one supplied instruction per request.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// request   in         push / full             cmd, instruction_word, mem_addr,
//                                              mem_value
// result    out        empty / pop             next_pc, overflow_flag,
//                                              read_value, done_res
// config    in         psel/penable/pwrite     paddr, pwdata, prdata
//
// Throughput is one request per cycle once the pipe is full, while results are
// popped. An accepted request is written into the input queue; its operands are
// then read from the register file and data memory (both have registered read
// ports) into the execute stage, which executes it and queues the result. After
// reset a clearing pass zeroes the data memory, one word a cycle, with full held
// high; config writes still land.
// A stalled result side backs up into the execute stage and then the queue.
//
module mini_risc_single_step_core_unit
  import mrsc_pkg::*;
#(
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Request side
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             cmd,
  input  logic [IO_W-1:0]        instruction_word,
  input  logic [MADDR_W-1:0]     mem_addr,
  input  logic signed [IO_W-1:0] mem_value,
  // Result side
  output logic                   empty,
  input  logic                   pop,
  output logic [PC_W-1:0]        next_pc,
  output logic                   overflow_flag,
  output logic signed [IO_W-1:0] read_value,
  output logic                   done_res,
  // Config port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  // Execution stops once the pc reaches this count.
  logic [PC_W-1:0] program_length;
  logic            cfg_hit;

  // Front to back
  logic            item_valid;
  item_t           item;
  logic            item_pop;
  logic            clearing;
  res_t            res;

  // Config register: one word at byte offset zero; the remaining bits of
  // paddr select a byte lane and are ignored.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[CFG_AW-1] == CFG_IDX_PROGRAM_LENGTH);
  assign prdata  = cfg_hit ? APB_DW'(program_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      program_length <= pwdata[PC_W-1:0];
    end
  end

  // Classify and queue requests; hold them off while memory clears.
  mrsc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .cmd              (cmd),
    .instruction_word (instruction_word),
    .mem_addr         (mem_addr),
    .mem_value        (mem_value),
    .hold             (clearing),
    .item_valid       (item_valid),
    .item             (item),
    .item_pop         (item_pop)
  );

  // Read operands, execute, update state and queue the result.
  mrsc_back #(
    .DATA_WORDS (DATA_WORDS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (item_valid),
    .in_item        (item),
    .in_pop         (item_pop),
    .program_length (program_length),
    .clearing       (clearing),
    .pop            (pop),
    .empty          (empty),
    .res            (res)
  );

  // Unpack the head result onto its ports.
  assign next_pc       = res.next_pc;
  assign overflow_flag = res.overflow_flag;
  assign read_value    = res.read_value;
  assign done_res      = res.done_res;

endmodule

>>> hw/rtl/mrsc_checker.sv
// ----------------------------------------------------------------------------
// mrsc_checker
// Port-level checks of the core, bound to the top level.
// ----------------------------------------------------------------------------
`include "mini_risc_single_step_core_unit_defines.svh"

module mrsc_checker
  import mrsc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   full,
  input logic                   empty,
  input logic                   pop,
  input logic [PC_W-1:0]        next_pc,
  input logic                   overflow_flag,
  input logic signed [IO_W-1:0] read_value,
  input logic                   done_res,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic                   pready,
  input logic [CFG_AW-1:0]      paddr,
  input logic [APB_DW-1:0]      pwdata,
  input logic [APB_DW-1:0]      prdata
);

  // Leaving reset: no results, and requests held off by the memory clear.
  `MRSC_ASSERT_SAME(a_reset_state, clk, rst, $past(rst), empty && full, "reset state wrong")

  // Overflow is sticky across results.
  `MRSC_ASSERT_NEXT(a_ovf_sticky, clk, rst, pop && !empty && overflow_flag, empty || overflow_flag, "overflow flag dropped")

  // A waiting result holds.
  `MRSC_ASSERT_NEXT(a_res_hold, clk, rst, !empty && !pop, !empty && $stable(next_pc) && $stable(read_value) && $stable(done_res) && $stable(overflow_flag), "result changed while waiting")

  // Program length reads back what was written.
  `MRSC_ASSERT_NEXT(a_cfg_back, clk, rst, psel && penable && pwrite && pready && (paddr[CFG_AW-1] == CFG_IDX_PROGRAM_LENGTH), (paddr[CFG_AW-1] != CFG_IDX_PROGRAM_LENGTH) || (prdata[PC_W-1:0] == $past(pwdata[PC_W-1:0])), "program length readback wrong")

endmodule

bind mini_risc_single_step_core_unit mrsc_checker u_mrsc_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .next_pc       (next_pc),
  .overflow_flag (overflow_flag),
  .read_value    (read_value),
  .done_res      (done_res),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .pready        (pready),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mini RISC single-step core. A directed table
// covers reset values, field extremes, every operation, overflow at both
// ends, jumps past the program end and the program counter wrap. Random
// phases then run well-formed programs under several program lengths and
// handshake pressure. Every result is checked against an in-bench model or a hand-written result.
// ----------------------------------------------------------------------------
module testbench
  import mrsc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         HALF_PERIOD  = 5;
  localparam int         RESET_CYCLES = 12;
  // Idle-cycle limit: covers the clearing pass after reset and long stalls
  localparam int         STALL_LIMIT  = 3000;
  localparam int         TAIL_CYCLES  = 20;
  localparam int         MAX_LEN      = 256;
  localparam logic [1:0] CMD_NONE     = 2'd3;
  localparam logic [3:0] OPC_UNUSED   = 4'd7;
  localparam logic [2:0] FN_UNUSED    = 3'd1;
  localparam logic [CFG_AW-1:0] PLEN_ADDR = CFG_AW'(4 * CFG_IDX_PROGRAM_LENGTH);

  typedef struct packed {
    logic [1:0]         cmd;
    logic [IO_W-1:0]    word;
    logic [MADDR_W-1:0] addr;
    logic [IO_W-1:0]    value;
  } req_t;

  // One line of a directed program: a register write or a request, the
  // latter optionally carrying a hand-written result
  typedef struct packed {
    logic        cfg;
    logic [8:0]  len;
    req_t        req;
    logic        typed;
    res_t        res;
  } plan_row_t;

  // DUT ports
  logic                   clk = 1'b0;
  logic                   rst;
  logic                   push;
  logic                   full;
  logic [1:0]             cmd;
  logic [IO_W-1:0]        instruction_word;
  logic [MADDR_W-1:0]     mem_addr;
  logic signed [IO_W-1:0] mem_value;
  logic                   empty;
  logic                   pop;
  logic [PC_W-1:0]        next_pc;
  logic                   overflow_flag;
  logic signed [IO_W-1:0] read_value;
  logic                   done_res;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_AW-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  // Core state as the bench sees it
  logic [IO_W-1:0] gpr [REG_COUNT];
  logic [IO_W-1:0] dmem [DATA_WORDS_DEF];
  logic [PC_W-1:0] core_pc;
  logic            ovf_sticky;
  logic [8:0]      prog_len;

  res_t      awaited [$];
  res_t      head;
  plan_row_t plan [$];
  int        failures = 0;
  int        quiet_cycles = 0;
  int        sender_idle_pct = 0;
  int        result_stall_pct = 0;

  mini_risc_single_step_core_unit uut (.*);

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Model of the core
  // ---------------------------------------------------------------------------

  // Drop out-of-range sums to zero and raise the sticky flag
  function automatic void write_arith(input logic [REG_AW-1:0] dst, input int v);
    if (v < ARITH_LO || v > ARITH_HI) begin
      gpr[dst] = '0;
      ovf_sticky = 1'b1;
    end else begin
      gpr[dst] = IO_W'(v);
    end
  endfunction

  function automatic res_t run_core_step(input req_t q);
    res_t               r;
    logic [3:0]         opc;
    logic [REG_AW-1:0]  rs, rt, rd;
    logic [2:0]         fn;
    int                 imm, tgt, a, b, npc;
    logic [MADDR_W-1:0] daddr;
    r     = '0;
    opc   = q.word[15:12];
    rs    = q.word[11:9];
    rt    = q.word[8:6];
    rd    = q.word[5:3];
    fn    = q.word[2:0];
    imm   = int'($signed(q.word[5:0]));
    tgt   = int'($signed(q.word[6:0]));
    daddr = MADDR_W'(imm);
    a     = int'($signed(gpr[rs]));
    b     = int'($signed(gpr[rt]));
    case (q.cmd)
      CMD_EXEC: begin
        if (core_pc >= prog_len) begin
          r.done_res = 1'b1;
        end else begin
          npc = int'(core_pc) + 1;
          case (opc)
            OPC_RTYPE: begin
              case (fn)
                FN_ADD:  write_arith(rd, a + b);
                FN_SUB:  write_arith(rd, a - b);
                FN_AND:  gpr[rd] = gpr[rs] & gpr[rt];
                FN_OR:   gpr[rd] = gpr[rs] | gpr[rt];
                default: ;
              endcase
            end
            OPC_ADDI: write_arith(rt, a + imm);
            OPC_LW:   gpr[rt] = dmem[daddr];
            OPC_SW:   dmem[daddr] = gpr[rt];
            OPC_BEQ:  if (gpr[rs] == gpr[rt]) npc = int'(core_pc) + imm + 1;
            OPC_J:    npc = (tgt - 1 < int'(prog_len)) ? tgt : tgt - 1;
            default:  ;
          endcase
          core_pc = PC_W'(npc);
        end
      end
      CMD_WRITE: dmem[q.addr] = q.value;
      CMD_READ:  r.read_value = dmem[q.addr];
      default:   ;
    endcase
    r.next_pc       = core_pc;
    r.overflow_flag = ovf_sticky;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [IO_W-1:0] enc_r(input int rs, rt, rd, input logic [2:0] fn);
    return {OPC_RTYPE, 3'(rs), 3'(rt), 3'(rd), fn};
  endfunction

  function automatic logic [IO_W-1:0] enc_i(input logic [3:0] op, input int rs, rt, imm);
    return {op, 3'(rs), 3'(rt), IMM_W'(imm)};
  endfunction

  function automatic logic [IO_W-1:0] enc_j(input int tgt);
    return {OPC_J, 5'd0, TGT_W'(tgt)};
  endfunction

  function automatic plan_row_t req_row(input logic [1:0] c, input logic [IO_W-1:0] w,
                                        input int a, input int v);
    plan_row_t p;
    p     = '0;
    p.req = '{c, w, MADDR_W'(a), IO_W'(v)};
    return p;
  endfunction

  function automatic plan_row_t typed_row(input logic [1:0] c, input logic [IO_W-1:0] w,
                                          input int a, input int v, input int pc,
                                          input logic ovf, input int rv, input logic dn);
    plan_row_t p;
    p       = req_row(c, w, a, v);
    p.typed = 1'b1;
    p.res   = '{PC_W'(pc), ovf, IO_W'(rv), dn};
    return p;
  endfunction

  function automatic plan_row_t cfg_row(input int len);
    plan_row_t p;
    p     = '0;
    p.cfg = 1'b1;
    p.len = 9'(len);
    return p;
  endfunction

  // Random instruction that keeps the program counter inside the program,
  // apart from rare deliberate runs past the end
  function automatic logic [IO_W-1:0] pick_instruction();
    logic [IO_W-1:0] w;
    int              pcv, lenv, lo, hi, top;
    w    = IO_W'($urandom);
    pcv  = int'(core_pc);
    lenv = int'(prog_len);
    top  = (lenv - 1 < 63) ? lenv - 1 : 63;
    case ($urandom_range(15))
      0, 1, 2, 3: begin
        w[15:12] = OPC_RTYPE;
        // mostly legal functs, the rest fall where they land
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(3))
            0:       w[2:0] = FN_ADD;
            1:       w[2:0] = FN_SUB;
            2:       w[2:0] = FN_AND;
            default: w[2:0] = FN_OR;
          endcase
        end
      end
      4, 5: w[15:12] = OPC_ADDI;
      6, 7: w[15:12] = OPC_LW;
      8, 9: w[15:12] = OPC_SW;
      10, 11: begin
        // bound the offset so both outcomes stay inside the program
        w[15:12] = OPC_BEQ;
        lo = (-pcv - 1 > -32) ? -pcv - 1 : -32;
        hi = (lenv - 2 - pcv < 31) ? lenv - 2 - pcv : 31;
        if (hi >= lo) w[5:0] = IMM_W'(lo + int'($urandom_range(hi - lo)));
      end
      12: begin
        w[15:12] = OPC_J;
        w[6:0]   = TGT_W'($urandom_range(top));
      end
      13: begin
        // may land past the end of a short program
        w[15:12] = OPC_J;
        w[6:0]   = TGT_W'($urandom_range(63));
      end
      default: begin
        // noise: keep random words away from unbounded branches
        if (w[15:12] == OPC_BEQ || w[15:12] == OPC_J) w[15:12] = OPC_UNUSED;
      end
    endcase
    // On the last slot jump back, except for an occasional run off the end
    if (pcv == lenv - 1 && w[15:12] != OPC_J &&
        (w[15:12] == OPC_BEQ || lenv == MAX_LEN || $urandom_range(31) != 0)) begin
      w[15:12] = OPC_J;
      w[6:0]   = TGT_W'($urandom_range(top));
    end
    return w;
  endfunction

  function automatic req_t pick_request();
    req_t q;
    int   sel;
    logic halted;
    q.cmd   = CMD_NONE;
    q.word  = IO_W'($urandom);
    q.addr  = MADDR_W'($urandom);
    q.value = IO_W'($urandom);
    halted  = core_pc >= prog_len;
    sel     = $urandom_range(99);
    // half the memory traffic targets words that loads and stores can reach
    if ($urandom_range(1) != 0) q.addr = {{2{q.addr[5]}}, q.addr[5:0]};
    if (sel < (halted ? 20 : 62)) begin
      q.cmd  = CMD_EXEC;
      q.word = halted ? q.word : pick_instruction();
    end else if (sel < 80) begin
      q.cmd = CMD_WRITE;
    end else if (sel < 96) begin
      q.cmd = CMD_READ;
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus drivers
  // ---------------------------------------------------------------------------

  // Present one request, idle first at random, and log its result on accept
  task automatic offer(input req_t q, input logic typed, input res_t typed_res);
    res_t r;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push             <= 1'b1;
    cmd              <= q.cmd;
    instruction_word <= q.word;
    mem_addr         <= q.addr;
    mem_value        <= q.value;
    @(posedge clk);
    while (full) @(posedge clk);
    r = run_core_step(q);
    awaited.push_back(typed ? typed_res : r);
  endtask

  task automatic quiesce();
    @(negedge clk);
    push <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  // Write program_length while idle, then read it back
  task automatic set_program_length(input logic [8:0] len);
    quiesce();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PLEN_ADDR;
    pwdata  <= APB_DW'(len);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    prog_len = len;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DW'(len)) begin
      $error("prdata: expected %0d, got %0d", len, prdata);
      failures++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic walk_plan();
    foreach (plan[i]) begin
      if (plan[i].cfg) set_program_length(plan[i].len);
      else offer(plan[i].req, plan[i].typed, plan[i].res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall at random, check every accepted result
  // ---------------------------------------------------------------------------

  always @(negedge clk) pop <= ($urandom_range(99) >= result_stall_pct);

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (awaited.size() == 0) begin
        $error("result popped with nothing awaited (next_pc %0d)", next_pc);
        failures++;
      end else begin
        head = awaited.pop_front();
        if (next_pc !== head.next_pc) begin
          $error("next_pc: expected %0d, got %0d", head.next_pc, next_pc);
          failures++;
        end
        if (overflow_flag !== head.overflow_flag) begin
          $error("overflow_flag: expected %0b, got %0b", head.overflow_flag, overflow_flag);
          failures++;
        end
        if (read_value !== head.read_value) begin
          $error("read_value: expected %0h, got %0h", head.read_value, read_value);
          failures++;
        end
        if (done_res !== head.done_res) begin
          $error("done_res: expected %0b, got %0b", head.done_res, done_res);
          failures++;
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted request or result
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int   idle_pct [6];
    int   stall_pct [6];
    int   lens [6];
    int   counts [6];
    int   n;
    logic ignored;
    logic paused;
    req_t q;

    rst              = 1'b1;
    push             = 1'b0;
    cmd              = CMD_EXEC;
    instruction_word = '0;
    mem_addr         = '0;
    mem_value        = '0;
    pop              = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    core_pc    = '0;
    ovf_sticky = 1'b0;
    prog_len   = '0;
    paused     = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed program: reset values, every operation, overflow at both
    // ends, a jump past a short program and recovery by a longer one
    plan = '{
      typed_row(CMD_EXEC, enc_r(0, 0, 0, FN_ADD), 0, 0, 0, 1'b0, 0, 1'b1),
      typed_row(CMD_READ, '0, 0, 0, 0, 1'b0, 0, 1'b0),
      typed_row(CMD_NONE, '1, 255, -1, 0, 1'b0, 0, 1'b0),
      cfg_row(MAX_LEN),
      typed_row(CMD_WRITE, '0, 1, ARITH_HI, 0, 1'b0, 0, 1'b0),
      typed_row(CMD_WRITE, '0, 2, ARITH_LO, 0, 1'b0, 0, 1'b0),
      typed_row(CMD_WRITE, '0, 224, -32768, 0, 1'b0, 0, 1'b0),
      typed_row(CMD_READ, '0, 224, 0, 0, 1'b0, 16'h8000, 1'b0),
      req_row(CMD_EXEC, enc_i(OPC_LW, 0, 1, 1), 0, 0),
      req_row(CMD_EXEC, enc_i(OPC_LW, 0, 2, 2), 0, 0),
      req_row(CMD_EXEC, enc_i(OPC_LW, 0, 7, -32), 0, 0),
      req_row(CMD_EXEC, enc_r(1, 0, 3, FN_ADD), 0, 0),
      req_row(CMD_EXEC, enc_r(2, 0, 4, FN_SUB), 0, 0),
      req_row(CMD_EXEC, enc_r(7, 1, 5, FN_AND), 0, 0),
      req_row(CMD_EXEC, enc_r(7, 1, 6, FN_OR), 0, 0),
      req_row(CMD_EXEC, enc_i(OPC_SW, 0, 6, 3), 0, 0),
      req_row(CMD_READ, '0, 3, 0),
      req_row(CMD_EXEC, enc_i(OPC_BEQ, 1, 1, 2), 0, 0),
      req_row(CMD_EXEC, enc_i(OPC_BEQ, 1, 2, -5), 0, 0),
      req_row(CMD_EXEC, enc_r(1, 2, 3, FN_UNUSED), 0, 0),
      req_row(CMD_EXEC, enc_i(OPC_UNUSED, 1, 2, 9), 0, 0),
      typed_row(CMD_EXEC, enc_j(0), 0, 0, 0, 1'b0, 0, 1'b0),
      req_row(CMD_EXEC, enc_i(OPC_ADDI, 1, 5, 31), 0, 0),
      req_row(CMD_EXEC, enc_i(OPC_ADDI, 2, 6, -32), 0, 0),
      cfg_row(10),
      typed_row(CMD_EXEC, enc_j(20), 0, 0, 19, 1'b1, 0, 1'b0),
      typed_row(CMD_EXEC, enc_j(0), 0, 0, 19, 1'b1, 0, 1'b1),
      cfg_row(MAX_LEN)
    };
    walk_plan();

    // Random phases: idle and stall pattern, program length and request count each
    idle_pct  = '{0, 88, 0, 32, 0, 32};
    stall_pct = '{0, 0, 88, 32, 0, 32};
    lens      = '{MAX_LEN, $urandom_range(63, 2), MAX_LEN, $urandom_range(255, 64), 1, 0};
    counts    = '{100, 90, 90, 90, 20, 20};
    foreach (lens[p]) begin
      sender_idle_pct  = 0;
      result_stall_pct = 0;
      set_program_length(9'(lens[p]));
      sender_idle_pct  = idle_pct[p];
      result_stall_pct = stall_pct[p];
      n = 0;
      while (n < counts[p]) begin
        q       = pick_request();
        ignored = (q.cmd == CMD_NONE) || (q.cmd == CMD_EXEC && core_pc >= prog_len);
        if (!ignored) n++;
        offer(q, 1'b0, '0);
        // hold off once mid-phase until every result is back
        if (!paused && idle_pct[p] == 32 && n == counts[p] / 2) begin
          quiesce();
          paused = 1'b1;
        end
      end
    end

    // Closing program: a negative jump wraps the counter high for good
    sender_idle_pct  = 0;
    result_stall_pct = 0;
    plan = '{
      cfg_row(MAX_LEN),
      typed_row(CMD_EXEC, enc_j(-1), 0, 0, 511, 1'b1, 0, 1'b0),
      typed_row(CMD_EXEC, enc_r(0, 0, 0, FN_ADD), 0, 0, 511, 1'b1, 0, 1'b1),
      typed_row(CMD_NONE, '1, 255, -1, 511, 1'b1, 0, 1'b0),
      req_row(CMD_READ, '0, 3, 0)
    };
    walk_plan();

    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
